[hdl/whfa_pkg.sv]
// Package for the worst-fit heap allocator: widths, codes, table entry, request and result types.
// No dependencies.
package whfa_pkg;

   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 24;
   localparam int ARENA_MAX        = 65536;
   localparam int ARENA_FLOOR      = 64;

   localparam int SW  = 17;
   localparam int OFW = 16;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic [SW-1:0] start;
      logic [SW-1:0] size;
      logic          used;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0]     status;
      logic [OFW-1:0] offset;
      logic [SW-1:0]  free_bytes;
   } result_type;

   typedef struct packed {
      logic mode;
      logic [15:0] req_size;
      logic [15:0] free_offset;
   } request_type;

endpackage

[hdl/whfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module whfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/whfa_seq.sv]
// Sequencer for the allocator: scans, shifts and merges the block table one entry per step.
// Depends on whfa_pkg and whfa_ram.
module whfa_seq
   import whfa_pkg::*;
#(
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [SW-1:0] arena,
   input  logic          init_req,
   input  logic          start,
   input  request_type   req,
   input  logic          out_ready,
   output logic          idle,
   output logic          res_valid,
   output result_type    res
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);
   localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SCAN, S_EVAL, S_SHR, S_SHW, S_WA1, S_WA2,
      S_FM, S_FW, S_SDR, S_SDW, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, ptr_ff, ptr_in;
   logic [SW-1:0] free_ff, free_in;
   request_type   req_ff, req_in;
   result_type    res_ff, res_in;
   logic          found_ff, found_in, cap_ff, cap_in, rval_ff, rval_in;
   logic [CW-1:0] bidx_ff, bidx_in, pos_ff, pos_in;
   logic [1:0]    d_ff, d_in;
   entry_type     best_ff, best_in, prev_ff, prev_in, left_ff, left_in, right_ff, right_in;
   entry_type     mrg_ff, mrg_in;
   logic [AW-1:0] maddr_ff, maddr_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;
   logic [SW-1:0] need;
   logic [SW:0]   hsum;
   logic          last;

   whfa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign need = SW'({1'b0, req_ff.req_size}) + HDR;
   assign hsum = {1'b0, rd_data.start} + {1'b0, HDR};
   assign last = ({1'b0, ptr_ff} + 1'b1) >= {1'b0, count_ff};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      free_in  = free_ff;
      req_in   = req_ff;
      res_in   = res_ff;
      found_in = found_ff;
      cap_in   = cap_ff;
      rval_in  = rval_ff;
      bidx_in  = bidx_ff;
      pos_in   = pos_ff;
      d_in     = d_ff;
      best_in  = best_ff;
      prev_in  = prev_ff;
      left_in  = left_ff;
      right_in = right_ff;
      mrg_in   = mrg_ff;
      maddr_in = maddr_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff[AW-1:0];
      wr_data  = rd_data;
      rd_addr  = '0;
      res_valid = 1'b0;
      case (state_ff)
         S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{start: '0, size: arena - (HDR << 1), used: 1'b0};
            count_in = CW'(1);
            free_in  = arena - (HDR << 1);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            rd_addr = '0;
            if (init_req) begin
               state_in = S_INIT;
            end else if (start) begin
               req_in   = req;
               ptr_in   = '0;
               found_in = 1'b0;
               cap_in   = 1'b0;
               rval_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_addr = AW'(ptr_ff + 1'b1);
            if (req_ff.mode == MODE_ALLOC) begin
               if (!rd_data.used && rd_data.size >= need &&
                   (!found_ff || rd_data.size > best_ff.size)) begin
                  found_in = 1'b1;
                  bidx_in  = ptr_ff;
                  best_in  = rd_data;
               end
            end else begin
               if (rd_data.used && hsum == {2'b0, req_ff.free_offset}) begin
                  found_in = 1'b1;
                  bidx_in  = ptr_ff;
                  best_in  = rd_data;
                  left_in  = prev_ff;
                  cap_in   = 1'b1;
                  rval_in  = 1'b0;
               end else if (cap_ff) begin
                  cap_in   = 1'b0;
                  rval_in  = 1'b1;
                  right_in = rd_data;
               end
            end
            prev_in = rd_data;
            ptr_in  = ptr_ff + 1'b1;
            if (last) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            res_in.offset = '0;
            if (req_ff.mode == MODE_ALLOC) begin
               if (found_ff && {1'b0, req_ff.req_size} < free_ff && count_ff < MAXC) begin
                  ptr_in = count_ff;
                  if ({1'b0, count_ff} > {1'b0, bidx_ff} + 1'b1) begin
                     state_in = S_SHR;
                  end else begin
                     state_in = S_WA1;
                  end
               end else begin
                  res_in.status     = ST_NOFIT;
                  res_in.free_bytes = free_ff;
                  state_in          = S_DONE;
               end
            end else begin
               if (found_ff) begin
                  state_in = S_FM;
               end else begin
                  res_in.status     = ST_BADFREE;
                  res_in.free_bytes = free_ff;
                  state_in          = S_DONE;
               end
            end
         end
         S_SHR: begin
            rd_addr  = AW'(ptr_ff - 1'b1);
            state_in = S_SHW;
         end
         S_SHW: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rd_data;
            ptr_in  = ptr_ff - 1'b1;
            if ({1'b0, ptr_ff} - 1'b1 > {1'b0, bidx_ff} + 1'b1) begin
               state_in = S_SHR;
            end else begin
               state_in = S_WA1;
            end
         end
         S_WA1: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(bidx_ff + 1'b1);
            wr_data  = '{start: best_ff.start + need, size: best_ff.size - need, used: 1'b0};
            state_in = S_WA2;
         end
         S_WA2: begin
            wr_en    = 1'b1;
            wr_addr  = bidx_ff[AW-1:0];
            wr_data  = '{start: best_ff.start, size: SW'({1'b0, req_ff.req_size}), used: 1'b1};
            count_in = count_ff + 1'b1;
            free_in  = free_ff - need;
            res_in.status     = ST_OK;
            res_in.offset     = OFW'(best_ff.start + HDR);
            res_in.free_bytes = free_ff - need;
            state_in = S_DONE;
         end
         S_FM: begin
            free_in = free_ff + best_ff.size + HDR;
            res_in.status     = ST_OK;
            res_in.free_bytes = free_ff + best_ff.size + HDR;
            mrg_in  = '{start: best_ff.start, size: best_ff.size, used: 1'b0};
            maddr_in = bidx_ff[AW-1:0];
            d_in    = 2'd0;
            pos_in  = bidx_ff + 1'b1;
            if (bidx_ff != '0 && !left_ff.used) begin
               mrg_in.start = left_ff.start;
               maddr_in = AW'(bidx_ff - 1'b1);
               pos_in   = bidx_ff;
               if (rval_ff && !right_ff.used) begin
                  mrg_in.size = left_ff.size + best_ff.size + right_ff.size + (HDR << 1);
                  d_in = 2'd2;
               end else begin
                  mrg_in.size = left_ff.size + best_ff.size + HDR;
                  d_in = 2'd1;
               end
            end else if (rval_ff && !right_ff.used) begin
               mrg_in.size = best_ff.size + right_ff.size + HDR;
               d_in = 2'd1;
            end
            state_in = S_FW;
         end
         S_FW: begin
            wr_en   = 1'b1;
            wr_addr = maddr_ff;
            wr_data = mrg_ff;
            ptr_in  = pos_ff;
            if (d_ff == 2'd0) begin
               state_in = S_DONE;
            end else if ({1'b0, pos_ff} + (CW+1)'(d_ff) < {1'b0, count_ff}) begin
               state_in = S_SDR;
            end else begin
               count_in = count_ff - CW'(d_ff);
               state_in = S_DONE;
            end
         end
         S_SDR: begin
            rd_addr  = AW'(ptr_ff + CW'(d_ff));
            state_in = S_SDW;
         end
         S_SDW: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rd_data;
            ptr_in  = ptr_ff + 1'b1;
            if ({1'b0, ptr_ff} + 1'b1 + (CW+1)'(d_ff) < {1'b0, count_ff}) begin
               state_in = S_SDR;
            end else begin
               count_in = count_ff - CW'(d_ff);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_ready) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         count_ff <= CW'(1);
         found_ff <= 1'b0;
         cap_ff   <= 1'b0;
         rval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         found_ff <= found_in;
         cap_ff   <= cap_in;
         rval_ff  <= rval_in;
      end
      ptr_ff   <= ptr_in;
      free_ff  <= free_in;
      req_ff   <= req_in;
      res_ff   <= res_in;
      bidx_ff  <= bidx_in;
      pos_ff   <= pos_in;
      d_ff     <= d_in;
      best_ff  <= best_in;
      prev_ff  <= prev_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      mrg_ff   <= mrg_in;
      maddr_ff <= maddr_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign res  = res_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= MAXC)
      else $error("block count out of range");
   a_init_count: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == S_INIT) |-> count_ff == CW'(1))
      else $error("table init left wrong count");
   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == ST_OK && req_ff.mode == MODE_ALLOC |->
      res.offset >= OFW'(HEADER_BYTES))
      else $error("allocated offset below header");
   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status != ST_OK |-> res.offset == '0)
      else $error("failed request with nonzero offset");
`endif

endmodule

[hdl/worst_fit_heap_allocator_unit.sv]
// Worst-fit heap allocator with coalescing: top level with arena register and result register.
// Depends on whfa_pkg, whfa_seq and whfa_ram.
//
// Usage:
//  - req channel (req_valid/req_stall): req_mode 0 allocates req_size bytes,
//    1 frees the block whose payload offset is req_free_offset.
//  - rsp channel (rsp_valid/rsp_stall): rsp_status, rsp_offset, rsp_free_bytes,
//    one result per request, in order.
//  - csr channel (csr_valid/csr_ready): csr_data sets the arena size (saturated
//    to its legal range) and reinitializes the table.
//  - One request at a time. Each request scans every block in the table; a
//    successful allocate or free also moves table entries as needed when an
//    allocate splits a block or a free merges neighbors, with one table read
//    and one table write per cycle.
//  - Reset loads a 65536-byte arena with one free block; req_stall stays high
//    for one cycle while entry 0 is written.
//  - A stalled result holds in the output register; the next request is taken
//    and processed, and waits at its end until the register drains.
module worst_fit_heap_allocator_unit
   import whfa_pkg::*;
#(
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_mode,
   input  logic [15:0]   req_size,
   input  logic [15:0]   req_free_offset,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic [15:0]   rsp_offset,
   output logic [16:0]   rsp_free_bytes,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [16:0]   csr_data
);

   localparam int LO = (2 * HEADER_BYTES > ARENA_FLOOR) ? 2 * HEADER_BYTES : ARENA_FLOOR;
   localparam logic [SW-1:0] ARENA_LO = SW'(LO);
   localparam logic [SW-1:0] ARENA_HI = SW'(ARENA_MAX);

   logic [SW-1:0] arena_ff, arena_in;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff, rsp_in;
   logic          idle, res_valid, out_ready, csr_xfer;
   result_type    res;
   request_type   req;

   assign req       = '{mode: req_mode, req_size: req_size, free_offset: req_free_offset};
   assign csr_ready = idle;
   assign csr_xfer  = csr_valid && csr_ready;
   assign req_stall = !idle || csr_valid;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   whfa_seq #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .arena     (arena_ff),
      .init_req  (csr_xfer),
      .start     (req_valid && !req_stall),
      .req       (req),
      .out_ready (out_ready),
      .idle      (idle),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      arena_in = arena_ff;
      if (csr_xfer) begin
         if (csr_data < ARENA_LO) begin
            arena_in = ARENA_LO;
         end else if (csr_data > ARENA_HI) begin
            arena_in = ARENA_HI;
         end else begin
            arena_in = csr_data;
         end
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_ff     <= ARENA_HI;
         rsp_valid_ff <= 1'b0;
      end else begin
         arena_ff     <= arena_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_offset     = rsp_ff.offset;
   assign rsp_free_bytes = rsp_ff.free_bytes;

endmodule
